// File: rtl/bfp_pkg.sv
// -----------------------------------------------------------------------------
// Binary frame parser package
// Shared constants, codes and types of the binary frame parser.
// -----------------------------------------------------------------------------
`default_nettype none

package bfp_pkg;

   // Largest payload length that is accepted; longer frames are dropped
   localparam int MAX_PAYLOAD = 256;
   localparam int COUNT_W     = $clog2(MAX_PAYLOAD + 1);

   localparam logic [7:0]  SYNC_FIRST   = 8'hF1;
   localparam logic [7:0]  SYNC_SECOND  = 8'hD9;
   localparam logic [7:0]  CLASS_ACK    = 8'h05;
   localparam logic [7:0]  CLASS_NAV    = 8'h01;
   localparam logic [7:0]  ID_ACK_OK    = 8'h01;
   localparam logic [7:0]  ID_POSITION  = 8'h02;
   localparam logic [15:0] ACK_LEN      = 16'd2;
   localparam logic [15:0] POSITION_LEN = 16'd28;
   localparam logic [15:0] MAX_LEN      = 16'(MAX_PAYLOAD);

   // Payload positions that are kept
   localparam logic [COUNT_W-1:0] ACK_CLASS_POS = COUNT_W'(0);
   localparam logic [COUNT_W-1:0] ACK_ID_POS    = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] ACC_FIRST_POS = COUNT_W'(20);
   localparam logic [COUNT_W-1:0] ACC_LAST_POS  = COUNT_W'(23);

   typedef enum logic [1:0] {
      EVENT_ACK      = 2'd0,
      EVENT_NAK      = 2'd1,
      EVENT_ACCURACY = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [7:0]  acked_class;
      logic [7:0]  acked_id;
      logic [31:0] horiz_accuracy_mm;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/bfp_stream_if.sv
// -----------------------------------------------------------------------------
// Binary frame parser channels
// Valid/ready channels for received bytes and for parser results.
// -----------------------------------------------------------------------------
`default_nettype none

interface bfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [7:0]  acked_class;
   logic [7:0]  acked_id;
   logic [31:0] horiz_accuracy_mm;

   modport source (output valid, output event_kind, output acked_class,
                   output acked_id, output horiz_accuracy_mm, input ready);
   modport sink   (input valid, input event_kind, input acked_class,
                   input acked_id, input horiz_accuracy_mm, output ready);
endinterface

`default_nettype wire

// File: rtl/binary_frame_parser_checksum_core.sv
// A result is presented in the cycle after the transfer of checksum byte B.
// Throughput: one byte per cycle, but for the checksum B hold described below.
// A result still waiting in the result register holds off only the checksum B
// byte of the next frame; every other byte is taken regardless of the result side.
// Reset: synchronous; returns the parser to sync scanning and empties the result
// register.
// -----------------------------------------------------------------------------
// Binary frame parser top level
// Finds binary frames in a received byte stream and reports ack and accuracy.
// -----------------------------------------------------------------------------
`default_nettype none

module binary_frame_parser_checksum_core (
   input  wire logic clock,
   input  wire logic reset,
   bfp_req_if.sink   req_chan,
   bfp_rsp_if.source rsp_chan
);
   import bfp_pkg::*;

   logic       accept;
   logic       at_check_b;
   logic       result_load;
   logic       slot_free;
   result_type result;
   result_type rsp_data;

   // hold only the byte that may raise a result while the last one waits
   assign req_chan.ready = slot_free || !at_check_b;
   assign accept         = req_chan.valid && req_chan.ready;

   bfp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_chan.rx_byte),
      .at_check_b  (at_check_b),
      .result_load (result_load),
      .result      (result)
   );

   bfp_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (result_load),
      .result    (result),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_data  (rsp_data),
      .slot_free (slot_free)
   );

   assign rsp_chan.event_kind        = rsp_data.event_kind;
   assign rsp_chan.acked_class       = rsp_data.acked_class;
   assign rsp_chan.acked_id          = rsp_data.acked_id;
   assign rsp_chan.horiz_accuracy_mm = rsp_data.horiz_accuracy_mm;

endmodule

`default_nettype wire

// File: rtl/bfp_parser.sv
// -----------------------------------------------------------------------------
// Binary frame parser state machine
// Finds sync, collects the header, runs the Fletcher sums and checks the frame.
// -----------------------------------------------------------------------------
`default_nettype none

module bfp_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         rx_byte,
   output logic                    at_check_b,
   output logic                    result_load,
   output bfp_pkg::result_type     result
);
   import bfp_pkg::*;

   typedef enum logic [3:0] {
      ST_SCAN    = 4'd0,
      ST_SYNC2   = 4'd1,
      ST_CLASS   = 4'd2,
      ST_ID      = 4'd3,
      ST_LEN_LO  = 4'd4,
      ST_LEN_HI  = 4'd5,
      ST_PAYLOAD = 4'd6,
      ST_CHECK_A = 4'd7,
      ST_CHECK_B = 4'd8
   } state_type;

   state_type          state_ff, state_in;
   logic [7:0]         class_ff, class_in;
   logic [7:0]         id_ff, id_in;
   logic [15:0]        length_ff, length_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         sum_a_ff, sum_a_in;
   logic [7:0]         sum_b_ff, sum_b_in;
   logic [7:0]         check_a_ff, check_a_in;
   logic [15:0]        ack_ff, ack_in;
   logic [31:0]        accuracy_ff, accuracy_in;

   logic [7:0]         sum_a_add;
   logic [7:0]         sum_b_add;
   logic [15:0]        length_full;
   logic [COUNT_W-1:0] count_next;

   assign sum_a_add   = sum_a_ff + rx_byte;
   assign sum_b_add   = sum_b_ff + sum_a_add;
   assign length_full = {rx_byte, length_ff[7:0]};
   assign count_next  = count_ff + COUNT_W'(1);

   // only the checksum B byte can raise a result
   assign at_check_b  = (state_ff == ST_CHECK_B);

   always_comb begin
      state_in    = state_ff;
      class_in    = class_ff;
      id_in       = id_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      check_a_in  = check_a_ff;
      ack_in      = ack_ff;
      accuracy_in = accuracy_ff;
      result_load = 1'b0;
      result      = '0;
      if (accept) begin
         unique case (state_ff)
            ST_SCAN: begin
               if (rx_byte == SYNC_FIRST) state_in = ST_SYNC2;
            end
            ST_SYNC2: begin
               if (rx_byte == SYNC_SECOND) begin
                  sum_a_in = '0;
                  sum_b_in = '0;
                  state_in = ST_CLASS;
               end else if (rx_byte != SYNC_FIRST) begin
                  state_in = ST_SCAN;
               end
            end
            ST_CLASS: begin
               class_in = rx_byte;
               sum_a_in = sum_a_add;
               sum_b_in = sum_b_add;
               state_in = ST_ID;
            end
            ST_ID: begin
               id_in    = rx_byte;
               sum_a_in = sum_a_add;
               sum_b_in = sum_b_add;
               state_in = ST_LEN_LO;
            end
            ST_LEN_LO: begin
               length_in = {8'h00, rx_byte};
               sum_a_in  = sum_a_add;
               sum_b_in  = sum_b_add;
               state_in  = ST_LEN_HI;
            end
            ST_LEN_HI: begin
               length_in = length_full;
               sum_a_in  = sum_a_add;
               sum_b_in  = sum_b_add;
               count_in  = '0;
               priority if (length_full == 16'd0) state_in = ST_CHECK_A;
               else if (length_full <= MAX_LEN)   state_in = ST_PAYLOAD;
               else                               state_in = ST_SCAN;
            end
            ST_PAYLOAD: begin
               // keep only the acknowledge target and the accuracy word
               if (count_ff == ACK_CLASS_POS) ack_in[7:0]  = rx_byte;
               if (count_ff == ACK_ID_POS)    ack_in[15:8] = rx_byte;
               if (count_ff >= ACC_FIRST_POS && count_ff <= ACC_LAST_POS)
                  accuracy_in[{count_ff[1:0], 3'b000} +: 8] = rx_byte;
               sum_a_in = sum_a_add;
               sum_b_in = sum_b_add;
               count_in = count_next;
               if (16'(count_next) >= length_ff) state_in = ST_CHECK_A;
            end
            ST_CHECK_A: begin
               check_a_in = rx_byte;
               state_in   = ST_CHECK_B;
            end
            ST_CHECK_B: begin
               if (sum_a_ff == check_a_ff && sum_b_ff == rx_byte) begin
                  if (class_ff == CLASS_ACK && length_ff == ACK_LEN) begin
                     result_load        = 1'b1;
                     result.event_kind  = (id_ff == ID_ACK_OK) ? EVENT_ACK : EVENT_NAK;
                     result.acked_class = ack_ff[7:0];
                     result.acked_id    = ack_ff[15:8];
                  end else if (class_ff == CLASS_NAV && id_ff == ID_POSITION &&
                               length_ff == POSITION_LEN) begin
                     result_load              = 1'b1;
                     result.event_kind        = EVENT_ACCURACY;
                     result.horiz_accuracy_mm = accuracy_ff;
                  end
               end
               state_in = ST_SCAN;
            end
            default: begin
               state_in = ST_SCAN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SCAN;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      class_ff    <= class_in;
      id_ff       <= id_in;
      length_ff   <= length_in;
      sum_a_ff    <= sum_a_in;
      sum_b_ff    <= sum_b_in;
      check_a_ff  <= check_a_in;
      ack_ff      <= ack_in;
      accuracy_ff <= accuracy_in;
   end

   a_result_only_at_check_b : assert property (@(posedge clock) disable iff (reset)
      result_load |-> state_ff == ST_CHECK_B)
      else $error("result raised outside the checksum B byte");

   a_check_b_returns_to_scan : assert property (@(posedge clock) disable iff (reset)
      accept && state_ff == ST_CHECK_B |=> state_ff == ST_SCAN)
      else $error("parser did not return to scanning after a frame");

   a_payload_count_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAYLOAD |-> 16'(count_ff) < length_ff && length_ff <= MAX_LEN)
      else $error("payload count out of range");

   a_sync_clears_sums : assert property (@(posedge clock) disable iff (reset)
      accept && state_ff == ST_SYNC2 && rx_byte == SYNC_SECOND
      |=> sum_a_ff == 8'h00 && sum_b_ff == 8'h00 && state_ff == ST_CLASS)
      else $error("checksum sums not cleared on sync");

endmodule

`default_nettype wire

// File: rtl/bfp_rsp_reg.sv
// -----------------------------------------------------------------------------
// Binary frame parser result register
// Holds one result until the downstream side takes the transfer.
// -----------------------------------------------------------------------------
`default_nettype none

module bfp_rsp_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire bfp_pkg::result_type result,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output bfp_pkg::result_type      rsp_data,
   output logic                     slot_free
);
   import bfp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // free only when empty, so slot_free has no combinational path from rsp_ready
   assign slot_free = !valid_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && rsp_ready) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire
